// ----- design/duart_pkg.sv -----
// Package for the dual UART register block: item codes, bit masks and packed types.
package duart_pkg;

  typedef enum logic [2:0] {
    MODE_READ  = 3'd0,
    MODE_WRITE = 3'd1,
    MODE_TICK  = 3'd2,
    MODE_RX_A  = 3'd3,
    MODE_RX_B  = 3'd4
  } item_mode_e;

  localparam logic [8:0] TX_CHAR_TICKS = 9'd368;

  localparam logic [7:0] SR_RXRDY = 8'h01;
  localparam logic [7:0] SR_TXRDY = 8'h04;
  localparam logic [7:0] SR_TXEMT = 8'h08;
  localparam logic [7:0] SR_ERRS  = 8'hf0;
  localparam logic [7:0] ISR_CNTR = 8'h08;

  localparam logic [2:0] CMD_RST_MR = 3'd1;
  localparam logic [2:0] CMD_RST_RX = 3'd2;
  localparam logic [2:0] CMD_RST_TX = 3'd3;
  localparam logic [2:0] CMD_RST_ER = 3'd4;

  localparam logic [2:0] REG_MR   = 3'd0;
  localparam logic [2:0] REG_SR   = 3'd1;
  localparam logic [2:0] REG_CR   = 3'd2;
  localparam logic [2:0] REG_HOLD = 3'd3;

  localparam logic [3:0] REG_ACR  = 4'd4;
  localparam logic [3:0] REG_ISR  = 4'd5;
  localparam logic [3:0] REG_CTU  = 4'd6;
  localparam logic [3:0] REG_CTL  = 4'd7;
  localparam logic [3:0] REG_IVR  = 4'd12;
  localparam logic [3:0] REG_OPCR = 4'd13;
  localparam logic [3:0] REG_SOP  = 4'd14;
  localparam logic [3:0] REG_ROP  = 4'd15;

  // input item tdata: mode[2:0], reg_addr[6:3], data_in[14:7]
  typedef struct packed {
    logic [7:0] data_in;
    logic [3:0] reg_addr;
    logic [2:0] mode;
  } in_item_t;

  // result item tdata: read_data, irq, tx_valid, tx_channel, tx_byte,
  // rx_free_a, rx_free_b, output_port
  typedef struct packed {
    logic [7:0] output_port;
    logic       rx_free_b;
    logic       rx_free_a;
    logic [7:0] tx_byte;
    logic       tx_channel;
    logic       tx_valid;
    logic       irq;
    logic [7:0] read_data;
  } out_item_t;

  function automatic logic [7:0] isr_tx_bit(input logic ch);
    return ch ? 8'h10 : 8'h01;
  endfunction

  function automatic logic [7:0] isr_rx_bit(input logic ch);
    return ch ? 8'h20 : 8'h02;
  endfunction

endpackage

// ----- design/dual_uart_register_model.sv -----
// Top level of the dual UART register block with counter/timer.
//
// Usage: each input item on s_axis (tdata: mode, reg_addr, data_in) is one
// bus read, bus write, X1 clock tick or received byte for channel A or B.
// Every accepted item yields exactly one result item on m_axis (tdata:
// read_data, irq, tx_valid, tx_channel, tx_byte, rx_free_a, rx_free_b,
// output_port). The register state is updated in the cycle the item is
// accepted and the result is held in an output register.
// The result appears in the cycle after acceptance.
// Throughput: one item per cycle; the state update is a single pass of
// bit logic and one 17-bit decrement, set by the counter/timer path.
// The input is taken whenever the output register is empty or is being
// emptied in the same cycle, so a stalled receiver holds the result and
// stops input only while it stalls.
// Reset clears all registers but the result payload, sets TxRDY and TxEMT in both status
// registers and stops the counter; no result is pending after reset.
// Mode codes five to seven change nothing but still return a result.
module dual_uart_register_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // mode[2:0], reg_addr[6:3], data_in[14:7], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // read_data[7:0], irq[8], tx_valid[9],
                                     // tx_channel[10], tx_byte[18:11],
                                     // rx_free_a[19], rx_free_b[20],
                                     // output_port[28:21], zero
);
  import duart_pkg::*;

  logic [7:0]  mr1_q [2];
  logic [7:0]  mr2_q [2];
  logic [7:0]  csr_q [2];
  logic        mrp_q [2];
  logic [7:0]  sr_q  [2];
  logic [7:0]  rhr_q [2];
  logic [8:0]  txb_q [2];
  logic [7:0]  mr1_d [2];
  logic [7:0]  mr2_d [2];
  logic [7:0]  csr_d [2];
  logic        mrp_d [2];
  logic [7:0]  sr_d  [2];
  logic [7:0]  rhr_d [2];
  logic [8:0]  txb_d [2];
  logic [7:0]  acr_q, imr_q, isr_q, ctu_q, ctl_q, ivr_q, opcr_q, op_q;
  logic [7:0]  acr_d, imr_d, isr_d, ctu_d, ctl_d, ivr_d, opcr_d, op_d;
  logic [16:0] cnt_q, cnt_d;
  logic        run_q, run_d, half_q, half_d;
  logic [15:0] frz_q, frz_d, rld_q, rld_d;
  logic [3:0]  pre_q, pre_d;

  logic        out_valid_q;
  out_item_t   out_q, res;
  in_item_t    item;
  logic        accept;

  assign item          = in_item_t'(s_axis_tdata[14:0]);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  // counter clock divider class from the current auxiliary control
  logic [1:0] sel;
  logic       div_none, div_16;
  logic [15:0] ct_val, preset;
  assign sel      = acr_q[5:4];
  assign div_16   = (sel == 2'd3);
  assign div_none = !acr_q[6] && (sel == 2'd1 || sel == 2'd2);
  assign ct_val   = div_none ? rld_q : (!run_q ? frz_q : cnt_q[15:0]);
  assign preset   = {ctu_q, ctl_q};

  logic       ch;
  logic [2:0] lo;
  logic [16:0] dec;
  assign ch  = item.reg_addr[3];
  assign lo  = item.reg_addr[2:0];
  assign dec = cnt_q - 17'd1;

  always_comb begin
    logic [15:0] ld;
    logic        do_load;
    for (int i = 0; i < 2; i++) begin
      mr1_d[i] = mr1_q[i]; mr2_d[i] = mr2_q[i]; csr_d[i] = csr_q[i];
      mrp_d[i] = mrp_q[i]; sr_d[i] = sr_q[i]; rhr_d[i] = rhr_q[i];
      txb_d[i] = txb_q[i];
    end
    acr_d = acr_q; imr_d = imr_q; isr_d = isr_q; ctu_d = ctu_q; ctl_d = ctl_q;
    ivr_d = ivr_q; opcr_d = opcr_q; op_d = op_q;
    cnt_d = cnt_q; run_d = run_q; half_d = half_q; frz_d = frz_q;
    rld_d = rld_q; pre_d = pre_q;
    ld = 16'h0000;
    do_load = 1'b0;
    res = '0;

    case (item.mode)
      MODE_READ: begin
        if (lo == REG_MR) begin
          if (!mrp_q[ch]) begin
            mrp_d[ch] = 1'b1;
            res.read_data = mr1_q[ch];
          end else begin
            res.read_data = mr2_q[ch];
          end
        end else if (lo == REG_SR) begin
          res.read_data = sr_q[ch];
        end else if (lo == REG_HOLD) begin
          res.read_data = rhr_q[ch];
          sr_d[ch] = sr_q[ch] & ~SR_RXRDY;
          isr_d = isr_q & ~isr_rx_bit(ch);
        end else if (lo != REG_CR) begin
          case (item.reg_addr)
            REG_ACR:  res.read_data = 8'h0f;
            REG_ISR:  res.read_data = isr_q;
            REG_CTU:  res.read_data = ct_val[15:8];
            REG_CTL:  res.read_data = ct_val[7:0];
            REG_IVR:  res.read_data = ivr_q;
            REG_OPCR: res.read_data = 8'hff;
            REG_SOP: begin
              half_d = 1'b0;
              ld = preset;
              do_load = 1'b1;
            end
            REG_ROP: begin
              frz_d = ct_val;
              run_d = 1'b0;
              isr_d = isr_q & ~ISR_CNTR;
            end
            default: ;
          endcase
        end
      end
      MODE_WRITE: begin
        if (lo == REG_MR) begin
          if (!mrp_q[ch]) begin
            mr1_d[ch] = item.data_in;
            mrp_d[ch] = 1'b1;
          end else begin
            mr2_d[ch] = item.data_in;
          end
        end else if (lo == REG_SR) begin
          csr_d[ch] = item.data_in;
        end else if (lo == REG_CR) begin
          case (item.data_in[6:4])
            CMD_RST_MR: mrp_d[ch] = 1'b0;
            CMD_RST_RX: begin
              sr_d[ch] = sr_q[ch] & ~(SR_RXRDY | SR_ERRS);
              isr_d = isr_q & ~isr_rx_bit(ch);
            end
            CMD_RST_TX: begin
              sr_d[ch] = sr_q[ch] | SR_TXRDY | SR_TXEMT;
              isr_d = isr_q & ~isr_tx_bit(ch);
            end
            CMD_RST_ER: sr_d[ch] = sr_q[ch] & ~SR_ERRS;
            default: ;
          endcase
        end else if (lo == REG_HOLD) begin
          // loop back into the receiver, or send to the line
          if (mr2_q[ch][7:6] == 2'b10) begin
            rhr_d[ch] = item.data_in;
            sr_d[ch] = (sr_q[ch] | SR_RXRDY) & ~(SR_TXRDY | SR_TXEMT);
            isr_d = (isr_q | isr_rx_bit(ch)) & ~isr_tx_bit(ch);
          end else begin
            res.tx_valid   = 1'b1;
            res.tx_channel = ch;
            res.tx_byte    = item.data_in;
            sr_d[ch] = sr_q[ch] & ~(SR_TXRDY | SR_TXEMT);
            isr_d = isr_q & ~isr_tx_bit(ch);
          end
          txb_d[ch] = TX_CHAR_TICKS;
        end else begin
          case (item.reg_addr)
            REG_ACR:  acr_d = item.data_in;
            REG_ISR:  imr_d = item.data_in;
            REG_CTU:  ctu_d = item.data_in;
            REG_CTL:  ctl_d = item.data_in;
            REG_IVR:  ivr_d = item.data_in;
            REG_OPCR: opcr_d = item.data_in;
            REG_SOP:  op_d = op_q | item.data_in;
            default:  op_d = op_q & ~item.data_in;
          endcase
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < 2; i++) begin
          if (txb_q[i] != 9'd0) begin
            txb_d[i] = txb_q[i] - 9'd1;
            if (txb_q[i] == 9'd1) begin
              sr_d[i] = sr_q[i] | SR_TXRDY | SR_TXEMT;
              isr_d = isr_d | isr_tx_bit(1'(i));
            end
          end
        end
        if (run_q && !div_none) begin
          if (div_16) pre_d = pre_q + 4'd1;
          if (!div_16 || pre_d == 4'd0) begin
            cnt_d = dec;
            if (dec == 17'd0) begin
              do_load = 1'b1;
              if (acr_q[6]) begin
                half_d = !half_q;
                if (half_q) isr_d = isr_d | ISR_CNTR;
                ld = preset;
              end else begin
                isr_d = isr_d | ISR_CNTR;
                ld = 16'hffff;
              end
            end
          end
        end
      end
      MODE_RX_A, MODE_RX_B: begin
        rhr_d[item.mode == MODE_RX_B] = item.data_in;
        sr_d[item.mode == MODE_RX_B] = sr_q[item.mode == MODE_RX_B] | SR_RXRDY;
        isr_d = isr_q | isr_rx_bit(item.mode == MODE_RX_B);
      end
      default: ;
    endcase

    if (do_load) begin
      rld_d = ld;
      cnt_d = (ld == 16'h0000) ? 17'h10000 : {1'b0, ld};
      run_d = !div_none;
      pre_d = 4'd0;
    end

    res.irq         = (isr_d & imr_d) != 8'h00;
    res.rx_free_a   = !sr_d[0][0];
    res.rx_free_b   = !sr_d[1][0];
    res.output_port = op_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        mr1_q[i] <= '0; mr2_q[i] <= '0; csr_q[i] <= '0; mrp_q[i] <= 1'b0;
        sr_q[i] <= SR_TXRDY | SR_TXEMT; rhr_q[i] <= '0; txb_q[i] <= '0;
      end
      acr_q <= '0; imr_q <= '0; isr_q <= '0; ctu_q <= '0; ctl_q <= '0;
      ivr_q <= '0; opcr_q <= '0; op_q <= '0;
      cnt_q <= '0; run_q <= 1'b0; half_q <= 1'b0; frz_q <= '0; rld_q <= '0;
      pre_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        for (int i = 0; i < 2; i++) begin
          mr1_q[i] <= mr1_d[i]; mr2_q[i] <= mr2_d[i]; csr_q[i] <= csr_d[i];
          mrp_q[i] <= mrp_d[i]; sr_q[i] <= sr_d[i]; rhr_q[i] <= rhr_d[i];
          txb_q[i] <= txb_d[i];
        end
        acr_q <= acr_d; imr_q <= imr_d; isr_q <= isr_d; ctu_q <= ctu_d;
        ctl_q <= ctl_d; ivr_q <= ivr_d; opcr_q <= opcr_d; op_q <= op_d;
        cnt_q <= cnt_d; run_q <= run_d; half_q <= half_d; frz_q <= frz_d;
        rld_q <= rld_d; pre_q <= pre_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result payload until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) out_q <= res;
  end

endmodule
